@@ src/kcc_pkg.sv @@
// shared types and constants for the k-mer co-occurrence counter
`default_nettype none
package kcc_pkg;

  // command codes of an input beat
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_step;     // clearing pass: write zero at clear address
    logic clr_adv;      // advance clear address
    logic capture;      // latch the input beat
    logic buf_rd;       // read set buffer at scan index
    logic pair_rd;      // read pair counter for buffered id
    logic pair_wr;      // write incremented pair counter
    logic scan_adv;     // advance scan index
    logic tmpl_rd;      // read template counters
    logic tmpl_wr;      // write incremented template count, append to set
    logic set_close;    // last_in_set handling
    logic q_rd;         // read counters for a query
    logic q_load;       // load result register
  } kcc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic id_ok;        // add id in range and room in set
    logic scan_done;    // all buffered ids visited
  } kcc_sts_t;

endpackage
`default_nettype wire

@@ src/kcc_ram.sv @@
// generic single-port-write, single-read RAM with registered read
`default_nettype none
module kcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/kcc_ctrl.sv @@
// controller state machine of the co-occurrence counter
`default_nettype none
module kcc_ctrl
  import kcc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire kcc_sts_t sts,
  output kcc_cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DECODE = 10'b0000000100,
    S_BUFRD  = 10'b0000001000,
    S_PAIRRD = 10'b0000010000,
    S_PAIRWAIT = 10'b0000100000,
    S_PAIRWR = 10'b0001000000,
    S_TMPL   = 10'b0010000000,
    S_QWAIT  = 10'b0100000000,
    S_QLOAD  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and command decode
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.clr_adv  = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_query) begin
          cmd.q_rd  = 1'b1;
          state_nxt = S_QWAIT;
        end else if (!sts.id_ok) begin
          cmd.set_close = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.scan_done) begin
          cmd.tmpl_rd = 1'b1;
          state_nxt   = S_TMPL;
        end else begin
          cmd.buf_rd = 1'b1;
          state_nxt  = S_BUFRD;
        end
      end
      S_BUFRD: begin
        cmd.pair_rd = 1'b1;
        state_nxt   = S_PAIRRD;
      end
      S_PAIRRD: begin
        state_nxt = S_PAIRWAIT;
      end
      S_PAIRWAIT: begin
        state_nxt = S_PAIRWR;
      end
      S_PAIRWR: begin
        cmd.pair_wr  = 1'b1;
        cmd.scan_adv = 1'b1;
        state_nxt    = S_DECODE;
      end
      S_TMPL: begin
        cmd.tmpl_wr   = 1'b1;
        cmd.set_close = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_QWAIT: begin
        state_nxt = S_QLOAD;
      end
      // hold the read counters until the result register is free
      S_QLOAD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.q_load    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a result is only produced from the read side of a query
  ap_load_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_load |-> $past(state_r == S_QWAIT || state_r == S_QLOAD))
    else $error("result loaded outside query");
  // no beat accepted during clearing pass
  ap_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall)
    else $error("input accepted while clearing");
  // pair write follows a pair read, through the PAIRRD and PAIRWAIT states
  ap_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pair_wr |-> $past(cmd.pair_rd, 3))
    else $error("pair write without read");

endmodule
`default_nettype wire

@@ src/kcc_dp.sv @@
// datapath: set buffer, counter memories, increment and distance logic
`default_nettype none
module kcc_dp
  import kcc_pkg::*;
#(
  parameter int MAX_TEMPLATES = 64,
  parameter int MAX_SET       = 64,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire kcc_cmd_t    cmd,
  output kcc_sts_t         sts,
  input  wire logic        in_command,
  input  wire logic [5:0]  in_template_id,
  input  wire logic [5:0]  in_other_id,
  input  wire logic        in_last_in_set,
  output logic [31:0]      out_shared_count,
  output logic [31:0]      out_count_first,
  output logic [31:0]      out_count_second,
  output logic [32:0]      out_kmer_distance,
  output logic             out_overflow_seen
);

  localparam int PAIR_DEPTH = MAX_TEMPLATES * (MAX_TEMPLATES + 1) / 2;
  localparam int PW = $clog2(PAIR_DEPTH);
  localparam int TW = $clog2(MAX_TEMPLATES);
  localparam int SW = $clog2(MAX_SET);
  localparam int LW = $clog2(MAX_SET + 1);
  localparam int CW = (PW > TW) ? PW : TW;
  localparam int IDW = 6;
  localparam int XW = ((IDW > TW) ? IDW : TW) + 1;
  localparam int DW = COUNT_BITS + 2;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  // captured beat
  logic           cmd_r;
  logic [IDW-1:0] a_r, b_r;
  logic           last_r;
  logic [LW-1:0]  len_r, scan_r;
  logic           ovf_r;
  logic [CW-1:0]  clr_r;
  logic           clr_done_r;

  // in-range checks on the full 6-bit ids
  logic a_ok, b_ok;
  assign a_ok = {{(XW-IDW){1'b0}}, a_r} < XW'(MAX_TEMPLATES);
  assign b_ok = {{(XW-IDW){1'b0}}, b_r} < XW'(MAX_TEMPLATES);

  // pair index hi*(hi+1)/2 + lo
  function automatic logic [PW-1:0] pidx(input logic [TW-1:0] x, input logic [TW-1:0] y);
    logic [TW-1:0] hi, lo;
    logic [2*TW:0] tri_v;
    hi = (x > y) ? x : y;
    lo = (x > y) ? y : x;
    tri_v = ({{(TW+1){1'b0}}, hi} * {{(TW){1'b0}}, hi} + {{(TW+1){1'b0}}, hi}) >> 1;
    return PW'(tri_v + {{(TW+1){1'b0}}, lo});
  endfunction

  // set buffer
  logic [TW-1:0] buf_rdata;
  logic [TW-1:0] a_t, b_t;
  assign a_t = TW'(a_r);
  assign b_t = TW'(b_r);

  kcc_ram #(.WIDTH(TW), .DEPTH(MAX_SET)) u_set (
    .clk(clk), .we(cmd.tmpl_wr), .waddr(SW'(len_r)), .wdata(a_t),
    .re(cmd.buf_rd), .raddr(SW'(scan_r)), .rdata(buf_rdata)
  );

  // pair counter memory, one read-modify-write per buffered id
  logic [PW-1:0]         p_raddr, p_waddr_r, p_waddr;
  logic [COUNT_BITS-1:0] p_rdata, p_wdata, p_inc_r;
  logic                  p_we;
  assign p_raddr = cmd.q_rd ? pidx(a_t, b_t) : pidx(a_t, buf_rdata);
  assign p_we    = cmd.clr_step ? (clr_r < CW'(PAIR_DEPTH)) : cmd.pair_wr;
  assign p_waddr = cmd.clr_step ? PW'(clr_r) : p_waddr_r;
  assign p_wdata = cmd.clr_step ? '0 : p_inc_r;

  kcc_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(cmd.pair_rd || cmd.q_rd), .raddr(p_raddr), .rdata(p_rdata)
  );

  // template counters: two read copies sharing writes
  logic [COUNT_BITS-1:0] ta_rdata, tb_rdata, t_wdata;
  logic                  t_we;
  logic [TW-1:0]         t_waddr;
  assign t_we    = cmd.clr_step ? (clr_r < CW'(MAX_TEMPLATES)) : cmd.tmpl_wr;
  assign t_waddr = cmd.clr_step ? TW'(clr_r) : a_t;
  assign t_wdata = cmd.clr_step ? '0 :
                   ((ta_rdata == CMAX) ? CMAX : ta_rdata + 1'b1);

  kcc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_TEMPLATES)) u_tmpl_a (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(cmd.tmpl_rd || cmd.q_rd), .raddr(a_t), .rdata(ta_rdata)
  );
  kcc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_TEMPLATES)) u_tmpl_b (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(cmd.q_rd), .raddr(b_t), .rdata(tb_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      scan_r     <= '0;
      ovf_r      <= 1'b0;
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else begin
      if (cmd.clr_adv) begin
        clr_r      <= clr_r + 1'b1;
        clr_done_r <= (clr_r >= CW'(PAIR_DEPTH - 1)) && (clr_r >= CW'(MAX_TEMPLATES - 1));
      end
      if (cmd.capture) begin
        scan_r <= '0;
      end
      if (cmd.scan_adv) begin
        scan_r <= scan_r + 1'b1;
      end
      // overflow only for in-range ids with a full set
      if (cmd.set_close && cmd_r == CMD_ADD && a_ok && len_r == LW'(MAX_SET)) begin
        ovf_r <= 1'b1;
      end
      if (cmd.tmpl_wr) begin
        len_r <= len_r + 1'b1;
      end
      if (cmd.set_close && last_r) begin
        len_r <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      a_r    <= in_template_id;
      b_r    <= in_other_id;
      last_r <= in_last_in_set;
    end
    if (cmd.pair_rd) begin
      p_waddr_r <= p_raddr;
    end
    // saturating pair increment, registered before write back
    p_inc_r <= (p_rdata == CMAX) ? CMAX : p_rdata + 1'b1;
  end

  // query result: clamp and distance
  logic [DW-1:0] sum_w, twice_w, dist_w;
  assign sum_w   = DW'(ta_rdata) + DW'(tb_rdata);
  assign twice_w = {1'b0, p_rdata, 1'b0};
  assign dist_w  = (twice_w >= sum_w) ? '0 : sum_w - twice_w;

  function automatic logic [31:0] clamp32(input logic [COUNT_BITS-1:0] v);
    logic [DW-1:0] w;
    w = DW'(v);
    return (w > DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      if (a_ok && b_ok) begin
        out_shared_count  <= clamp32(p_rdata);
        out_count_first   <= clamp32(ta_rdata);
        out_count_second  <= clamp32(tb_rdata);
        out_kmer_distance <= (dist_w > DW'(33'h1_FFFF_FFFF)) ? 33'h1_FFFF_FFFF
                                                            : dist_w[32:0];
      end else begin
        out_shared_count  <= '0;
        out_count_first   <= '0;
        out_count_second  <= '0;
        out_kmer_distance <= '0;
      end
      out_overflow_seen <= ovf_r;
    end
  end

  // status
  assign sts.clr_done  = clr_done_r;
  assign sts.is_query  = (cmd_r == CMD_QUERY);
  assign sts.id_ok     = a_ok && (len_r < LW'(MAX_SET));
  assign sts.scan_done = (scan_r >= len_r);

  // set length never exceeds capacity
  ap_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_SET))
    else $error("set length beyond buffer");
  // overflow flag is sticky
  ap_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ovf_r) |-> ovf_r)
    else $error("overflow flag cleared");
  // append only when room remains
  ap_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tmpl_wr |-> len_r < LW'(MAX_SET))
    else $error("append into full set");

endmodule
`default_nettype wire

@@ src/kmer_cooccurrence_counter_unit.sv @@
// top level of the k-mer co-occurrence counter
// add beat: a pair update per buffered id (states BUFRD, PAIRRD, PAIRWAIT, PAIRWR), then a template update
// dropped add beat (bad id or full set): DECODE returns to IDLE; query beat: read in DECODE, loaded in QLOAD
// one beat in flight; a query waits for a free result register before loading it
// after reset a clearing pass over every pair and template counter address
// zeroes the counter memories; input stalls during it
`default_nettype none
module kmer_cooccurrence_counter_unit
  import kcc_pkg::*;
#(
  parameter int MAX_TEMPLATES = 64,
  parameter int MAX_SET       = 64,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [5:0]  in_template_id,
  input  wire logic [5:0]  in_other_id,
  input  wire logic        in_last_in_set,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_shared_count,
  output logic [31:0]      out_count_first,
  output logic [31:0]      out_count_second,
  output logic [32:0]      out_kmer_distance,
  output logic             out_overflow_seen
);

  kcc_cmd_t cmd;
  kcc_sts_t sts;

  // controller
  kcc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  // datapath
  kcc_dp #(
    .MAX_TEMPLATES(MAX_TEMPLATES), .MAX_SET(MAX_SET), .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_command(in_command), .in_template_id(in_template_id),
    .in_other_id(in_other_id), .in_last_in_set(in_last_in_set),
    .out_shared_count(out_shared_count), .out_count_first(out_count_first),
    .out_count_second(out_count_second), .out_kmer_distance(out_kmer_distance),
    .out_overflow_seen(out_overflow_seen)
  );

endmodule
`default_nettype wire

@@ dv/kcc_checker.sv @@
// predictor and result checker for the k-mer co-occurrence counter
`timescale 1ns / 1ps
`default_nettype none
module kcc_checker
  import kcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_command,
  input  wire logic [5:0]  in_template_id,
  input  wire logic [5:0]  in_other_id,
  input  wire logic        in_last_in_set,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_shared_count,
  input  wire logic [31:0] out_count_first,
  input  wire logic [31:0] out_count_second,
  input  wire logic [32:0] out_kmer_distance,
  input  wire logic        out_overflow_seen,
  output int               error_count,
  output int               pending_count,
  output int               query_count
);

  localparam int NTMPL = 64;
  localparam int NSET = 64;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] shared;
    logic [31:0] first;
    logic [31:0] second;
    logic [32:0] kdist;
    logic        ovf;
  } answer_t;

  // model state
  logic [5:0]  open_ids [NSET];
  int          open_len;
  logic [31:0] pair_tally [NTMPL][NTMPL];
  logic [31:0] tmpl_tally [NTMPL];
  logic        ovf_sticky;
  answer_t     answers_due [$];

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  task automatic report(string what, logic [32:0] got, logic [32:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // pair tally kept on the lower triangle (hi, lo)
  task automatic add_id(logic [5:0] id, logic last);
    logic [5:0] hi, lo;
    if (open_len >= NSET) begin
      ovf_sticky = 1'b1;
    end else begin
      for (int k = 0; k < open_len; k++) begin
        hi = (id > open_ids[k]) ? id : open_ids[k];
        lo = (id > open_ids[k]) ? open_ids[k] : id;
        pair_tally[hi][lo] = bump(pair_tally[hi][lo]);
      end
      open_ids[open_len] = id;
      open_len++;
      tmpl_tally[id] = bump(tmpl_tally[id]);
    end
    if (last) open_len = 0;
  endtask

  function automatic answer_t answer_query(logic [5:0] a, logic [5:0] b);
    answer_t r;
    logic [5:0] hi, lo;
    logic [33:0] sum, twice;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    r.shared = pair_tally[hi][lo];
    r.first = tmpl_tally[a];
    r.second = tmpl_tally[b];
    sum = {2'b0, r.first} + {2'b0, r.second};
    twice = {1'b0, r.shared, 1'b0};
    r.kdist = (twice >= sum) ? 33'd0 : 33'(sum - twice);
    r.ovf = ovf_sticky;
    return r;
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      open_len = 0;
      ovf_sticky = 1'b0;
      for (int i = 0; i < NTMPL; i++) begin
        tmpl_tally[i] = '0;
        for (int j = 0; j < NTMPL; j++) pair_tally[i][j] = '0;
      end
      answers_due.delete();
      error_count = 0;
      query_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report("unexpected result beat", 33'd0, 33'd0);
        end else begin
          want = answers_due.pop_front();
          query_count++;
          if (out_shared_count !== want.shared)
            report("shared_count", out_shared_count, want.shared);
          if (out_count_first !== want.first)
            report("count_first", out_count_first, want.first);
          if (out_count_second !== want.second)
            report("count_second", out_count_second, want.second);
          if (out_kmer_distance !== want.kdist)
            report("kmer_distance", out_kmer_distance, want.kdist);
          if (out_overflow_seen !== want.ovf)
            report("overflow_seen", out_overflow_seen, want.ovf);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_command == CMD_ADD) add_id(in_template_id, in_last_in_set);
        else answers_due.push_back(answer_query(in_template_id, in_other_id));
      end
    end
    pending_count = answers_due.size();
  end

endmodule
`default_nettype wire

@@ dv/tb_kmer_cooccurrence_counter_unit.sv @@
// stimulus and verdict for the k-mer co-occurrence counter
`timescale 1ns / 1ps
`default_nettype none
module tb_kmer_cooccurrence_counter_unit;
  import kcc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_ADD;
  logic [5:0]  in_template_id = '0;
  logic [5:0]  in_other_id = '0;
  logic        in_last_in_set = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_shared_count, out_count_first, out_count_second;
  logic [32:0] out_kmer_distance;
  logic        out_overflow_seen;
  int          error_count, pending_count, query_count;
  int          send_idle_pct = 33, recv_idle_pct = 77;
  int          beat_total = 0;

  kmer_cooccurrence_counter_unit dut (.*);

  kcc_checker u_checker (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall, drawn each falling edge
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // one beat: random gap, then hold until accepted; returns at a falling edge
  task automatic send_beat(logic cmd, logic [5:0] a, logic [5:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_template_id <= a;
    in_other_id <= b;
    in_last_in_set <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beat_total++;
    @(negedge clk);
  endtask

  task automatic random_set();
    int n;
    n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
    for (int k = 0; k < n; k++)
      send_beat(CMD_ADD, ($urandom_range(3) == 0) ? 6'($urandom_range(3)) : 6'($urandom),
                6'($urandom), k == n - 1);
  endtask

  task automatic random_part(int beats);
    int start;
    start = beat_total;
    while (beat_total - start < beats) begin
      if ($urandom_range(2) == 0) random_set();
      else send_beat(CMD_QUERY, 6'($urandom), 6'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: extremes, pair order, repeated id, overflow
    send_beat(CMD_QUERY, 6'd63, 6'd0, 1'b1);
    send_beat(CMD_ADD, 6'd63, 6'h2A, 1'b0);
    send_beat(CMD_ADD, 6'd0, 6'h15, 1'b0);
    send_beat(CMD_ADD, 6'd63, 6'd0, 1'b1);
    send_beat(CMD_QUERY, 6'd0, 6'd63, 1'b0);
    send_beat(CMD_QUERY, 6'd63, 6'd0, 1'b0);
    send_beat(CMD_QUERY, 6'd63, 6'd63, 1'b0);
    for (int k = 0; k < 66; k++) send_beat(CMD_ADD, 6'(k), 6'h3F, k == 65);
    send_beat(CMD_QUERY, 6'd5, 6'd5, 1'b1);
    send_beat(CMD_QUERY, 6'd1, 6'd62, 1'b0);
    random_part(190);
    send_idle_pct = 77;
    recv_idle_pct = 33;
    random_part(190);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_part(190);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d beats, checked %0d query results", beat_total, query_count);
    $display("covered overflow, repeated ids, both pair orders, three idle mixes");
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
